// File: sv/rau_pkg.sv
// Shared codes and types for the rational arithmetic unit.
package rau_pkg;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_CMP = 3'd4;

  localparam logic [1:0] ORD_LESS    = 2'd0;
  localparam logic [1:0] ORD_EQUAL   = 2'd1;
  localparam logic [1:0] ORD_GREATER = 2'd2;

  localparam int RESULT_NUM_W = 32;
  localparam int RESULT_DEN_W = 31;

  typedef struct packed {
    logic       neg;
    logic [1:0] ord;
    logic       dz;
  } rau_side_t;

endpackage

// File: sv/rau_if.sv
// Request and result channel interfaces of the rational arithmetic unit.
interface rau_in_if #(parameter int OPERAND_WIDTH = 16);
  logic                            valid;
  logic                            ready;
  logic [2:0]                      op;
  logic signed [OPERAND_WIDTH-1:0] left_num;
  logic [OPERAND_WIDTH-2:0]        left_den;
  logic signed [OPERAND_WIDTH-1:0] right_num;
  logic [OPERAND_WIDTH-2:0]        right_den;

  modport source(output valid, op, left_num, left_den, right_num, right_den, input ready);
  modport sink(input valid, op, left_num, left_den, right_num, right_den, output ready);
endinterface

interface rau_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_num;
  logic [30:0]        result_den;
  logic [1:0]         order;
  logic               div_by_zero;

  modport source(output valid, result_num, result_den, order, div_by_zero, input ready);
  modport sink(input valid, result_num, result_den, order, div_by_zero, output ready);
endinterface

// File: sv/rau_gcd_stage.sv
// One registered binary GCD step of the reduction pipeline.
module rau_gcd_stage
  import rau_pkg::*;
#(
  parameter int M  = 32,
  parameter int KW = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          vld_i,
  input  rau_side_t     side_i,
  input  logic [M-1:0]  u_i,
  input  logic [M-1:0]  v_i,
  input  logic [KW-1:0] k_i,
  input  logic [M-1:0]  a_i,
  input  logic [M-1:0]  b_i,
  output logic          vld_o,
  output rau_side_t     side_o,
  output logic [M-1:0]  u_o,
  output logic [M-1:0]  v_o,
  output logic [KW-1:0] k_o,
  output logic [M-1:0]  a_o,
  output logic [M-1:0]  b_o
);

  logic [M-1:0]  u_next;
  logic [M-1:0]  v_next;
  logic [KW-1:0] k_next;
  logic [M-1:0]  diff_uv;
  logic [M-1:0]  diff_vu;

  assign diff_uv = u_i - v_i;
  assign diff_vu = v_i - u_i;

  always_comb begin
    u_next = u_i;
    v_next = v_i;
    k_next = k_i;
    priority if (u_i == '0 || v_i == '0) begin
      u_next = u_i;
    end else if (!u_i[0] && !v_i[0]) begin
      u_next = u_i >> 1;
      v_next = v_i >> 1;
      k_next = k_i + KW'(1);
    end else if (!u_i[0]) begin
      u_next = u_i >> 1;
    end else if (!v_i[0]) begin
      v_next = v_i >> 1;
    end else if (u_i >= v_i) begin
      u_next = diff_uv >> 1;
    end else begin
      v_next = diff_vu >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_o <= side_i;
      u_o    <= u_next;
      v_o    <= v_next;
      k_o    <= k_next;
      a_o    <= a_i;
      b_o    <= b_i;
    end
  end

endmodule

// File: sv/rau_div_stage.sv
// One registered restoring-division bit for numerator and denominator.
module rau_div_stage
  import rau_pkg::*;
#(
  parameter int M = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         vld_i,
  input  rau_side_t    side_i,
  input  logic [M-1:0] g_i,
  input  logic [M-1:0] ra_i,
  input  logic [M-1:0] qa_i,
  input  logic [M-1:0] rb_i,
  input  logic [M-1:0] qb_i,
  output logic         vld_o,
  output rau_side_t    side_o,
  output logic [M-1:0] g_o,
  output logic [M-1:0] ra_o,
  output logic [M-1:0] qa_o,
  output logic [M-1:0] rb_o,
  output logic [M-1:0] qb_o
);

  logic [M:0] ta;
  logic [M:0] tb;
  logic [M:0] da;
  logic [M:0] db;
  logic       ga;
  logic       gb;

  assign ta = {ra_i, qa_i[M-1]};
  assign tb = {rb_i, qb_i[M-1]};
  assign da = ta - {1'b0, g_i};
  assign db = tb - {1'b0, g_i};
  assign ga = ta >= {1'b0, g_i};
  assign gb = tb >= {1'b0, g_i};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_o <= side_i;
      g_o    <= g_i;
      ra_o   <= ga ? da[M-1:0] : ta[M-1:0];
      rb_o   <= gb ? db[M-1:0] : tb[M-1:0];
      qa_o   <= {qa_i[M-2:0], ga};
      qb_o   <= {qb_i[M-2:0], gb};
    end
  end

endmodule

// File: sv/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit: products, GCD and reducing divide.
//
//   channel   direction  interface    contents
//   operand   in         rau_in_if    op, left_num, left_den, right_num, right_den
//   result    out        rau_out_if   result_num, result_den, order, div_by_zero
//
// One request enters per cycle while no result waits unread. Each result passes the product and
// fraction stages, the 2*M GCD steps, the divisor stage and the M division bits, one per stage,
// then the output register; M is twice OPERAND_WIDTH.
// Reset clears only the valid bits of the stages.
// When a result waits unread, the whole pipeline holds and no request is taken.
module rational_arithmetic_unit
  import rau_pkg::*;
#(
  parameter int OPERAND_WIDTH = 16
) (
  input logic      clk,
  input logic      rst,
  rau_in_if.sink   operand,
  rau_out_if.source result
);

  localparam int W  = OPERAND_WIDTH;
  localparam int M  = 2 * W;
  localparam int KW = $clog2(M + 1);
  localparam int GS = 2 * M;
  localparam int XW = (M + 1 > RESULT_NUM_W) ? M + 1 : RESULT_NUM_W;
  localparam int DW = (M > RESULT_DEN_W) ? M : RESULT_DEN_W;

  logic adv;

  // Stage A: products.
  logic signed [W-1:0]   mx;
  logic                  va;
  logic [2:0]            op_a;
  logic signed [M-1:0]   pa;
  logic signed [M-1:0]   pb;
  logic [M-1:0]          pc;
  logic                  rnz;

  assign mx = (operand.op == OP_MUL) ? operand.right_num
                                     : signed'({1'b0, operand.right_den});

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (adv) begin
      va <= operand.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op_a <= operand.op;
      pa   <= M'(operand.left_num) * M'(mx);
      pb   <= M'(signed'({1'b0, operand.left_den})) * M'(operand.right_num);
      pc   <= M'(operand.left_den) * M'(operand.right_den);
      rnz  <= operand.right_num == '0;
    end
  end

  // Stage B: raw fraction, sign and magnitudes.
  logic signed [M-1:0] n;
  logic signed [M-1:0] d;
  logic                arith;
  logic                bypass;
  rau_side_t           side_b;
  logic [M-1:0]        mag_b;
  logic [M-1:0]        dmag_b;
  logic                vb;
  rau_side_t           side_r;
  logic [M-1:0]        mag_r;
  logic [M-1:0]        dmag_r;

  always_comb begin
    n     = '0;
    d     = '0;
    arith = 1'b1;
    unique case (op_a)
      OP_ADD: begin
        n = pa + pb;
        d = signed'(pc);
      end
      OP_SUB: begin
        n = pa - pb;
        d = signed'(pc);
      end
      OP_MUL: begin
        n = pa;
        d = signed'(pc);
      end
      OP_DIV: begin
        n = pa;
        d = pb;
      end
      default: begin
        arith = 1'b0;
      end
    endcase
  end

  always_comb begin
    bypass     = !arith || (op_a == OP_DIV && rnz) || d == '0;
    side_b.dz  = (op_a == OP_DIV) && rnz;
    side_b.ord = ORD_LESS;
    if (op_a == OP_CMP) begin
      side_b.ord = (pa < pb) ? ORD_LESS : ((pa == pb) ? ORD_EQUAL : ORD_GREATER);
    end
    side_b.neg = n[M-1] ^ d[M-1];
    mag_b      = n[M-1] ? M'(-n) : M'(n);
    dmag_b     = d[M-1] ? M'(-d) : M'(d);
    if (bypass) begin
      side_b.neg = 1'b0;
      mag_b      = '0;
      dmag_b     = M'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (adv) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r <= side_b;
      mag_r  <= mag_b;
      dmag_r <= dmag_b;
    end
  end

  // GCD chain.
  logic          gv [0:GS];
  rau_side_t     gsd[0:GS];
  logic [M-1:0]  gu [0:GS];
  logic [M-1:0]  gvv[0:GS];
  logic [KW-1:0] gk [0:GS];
  logic [M-1:0]  ga [0:GS];
  logic [M-1:0]  gb [0:GS];

  assign gv[0]  = vb;
  assign gsd[0] = side_r;
  assign gu[0]  = mag_r;
  assign gvv[0] = dmag_r;
  assign gk[0]  = '0;
  assign ga[0]  = mag_r;
  assign gb[0]  = dmag_r;

  for (genvar i = 0; i < GS; i++) begin : g_gcd
    rau_gcd_stage #(.M(M), .KW(KW)) u_stage (
      .clk   (clk),
      .rst   (rst),
      .en    (adv),
      .vld_i (gv[i]),
      .side_i(gsd[i]),
      .u_i   (gu[i]),
      .v_i   (gvv[i]),
      .k_i   (gk[i]),
      .a_i   (ga[i]),
      .b_i   (gb[i]),
      .vld_o (gv[i+1]),
      .side_o(gsd[i+1]),
      .u_o   (gu[i+1]),
      .v_o   (gvv[i+1]),
      .k_o   (gk[i+1]),
      .a_o   (ga[i+1]),
      .b_o   (gb[i+1])
    );
  end

  // Divisor stage: restore the common power of two.
  logic          dv [0:M];
  rau_side_t     dsd[0:M];
  logic [M-1:0]  dg [0:M];
  logic [M-1:0]  dra[0:M];
  logic [M-1:0]  dqa[0:M];
  logic [M-1:0]  drb[0:M];
  logic [M-1:0]  dqb[0:M];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (adv) begin
      dv[0] <= gv[GS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dsd[0] <= gsd[GS];
      dg[0]  <= (gu[GS] | gvv[GS]) << gk[GS];
      dra[0] <= '0;
      dqa[0] <= ga[GS];
      drb[0] <= '0;
      dqb[0] <= gb[GS];
    end
  end

  for (genvar j = 0; j < M; j++) begin : g_div
    rau_div_stage #(.M(M)) u_stage (
      .clk   (clk),
      .rst   (rst),
      .en    (adv),
      .vld_i (dv[j]),
      .side_i(dsd[j]),
      .g_i   (dg[j]),
      .ra_i  (dra[j]),
      .qa_i  (dqa[j]),
      .rb_i  (drb[j]),
      .qb_i  (dqb[j]),
      .vld_o (dv[j+1]),
      .side_o(dsd[j+1]),
      .g_o   (dg[j+1]),
      .ra_o  (dra[j+1]),
      .qa_o  (dqa[j+1]),
      .rb_o  (drb[j+1]),
      .qb_o  (dqb[j+1])
    );
  end

  // Output register.
  logic signed [XW-1:0] num_ext;
  logic [DW-1:0]        den_ext;

  assign num_ext = dsd[M].neg ? -XW'(dqa[M]) : XW'(dqa[M]);
  assign den_ext = DW'(dqb[M]);

  assign adv = !result.valid || result.ready;
  assign operand.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (adv) begin
      result.valid <= dv[M];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.result_num  <= num_ext[RESULT_NUM_W-1:0];
      result.result_den  <= den_ext[RESULT_DEN_W-1:0];
      result.order       <= dsd[M].ord;
      result.div_by_zero <= dsd[M].dz;
    end
  end

endmodule

// File: tb/sv/rau_checker.sv
// Checker that predicts and compares every result of the rational arithmetic unit.
`timescale 1ns / 1ps
module rau_checker
  import rau_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  rau_in_if.sink    operand_mon,
  rau_out_if.sink   result_mon,
  output int        fail_count,
  output int        pending_count
);

  typedef struct packed {
    logic signed [31:0] num;
    logic [30:0]        den;
    logic [1:0]         ord;
    logic               dz;
  } fraction_result_t;

  fraction_result_t expected_fractions[$];

  function automatic longint unsigned gcd_of(longint unsigned a, longint unsigned b);
    longint unsigned t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic fraction_result_t reduce_fraction(logic [2:0] op, logic signed [15:0] lnum,
                                                       logic [14:0] lden,
                                                       logic signed [15:0] rnum,
                                                       logic [14:0] rden);
    fraction_result_t r;
    longint ln, ld, rn, rd, n, d, a, b;
    longint unsigned mag, g;
    ln = lnum;
    ld = lden;
    rn = rnum;
    rd = rden;
    r.num = 0;
    r.den = 1;
    r.ord = ORD_LESS;
    r.dz = 1'b0;
    n = 0;
    d = 0;
    case (op)
      OP_ADD: begin
        n = ln * rd + ld * rn;
        d = ld * rd;
      end
      OP_SUB: begin
        n = ln * rd - ld * rn;
        d = ld * rd;
      end
      OP_MUL: begin
        n = ln * rn;
        d = ld * rd;
      end
      OP_DIV: begin
        if (rn == 0) begin
          r.dz = 1'b1;
          return r;
        end
        n = ln * rd;
        d = ld * rn;
      end
      OP_CMP: begin
        a = ln * rd;
        b = ld * rn;
        r.ord = (a < b) ? ORD_LESS : ((a == b) ? ORD_EQUAL : ORD_GREATER);
        return r;
      end
      default: return r;
    endcase
    if (d == 0) return r;
    if (d < 0) begin
      d = -d;
      n = -n;
    end
    mag = (n < 0) ? longint'(-n) : longint'(n);
    g = gcd_of(mag, d);
    if (g > 1) begin
      n = (n < 0) ? -longint'(mag / g) : longint'(mag / g);
      d = d / longint'(g);
    end
    r.num = n[31:0];
    r.den = d[30:0];
    return r;
  endfunction

  always @(posedge clk) begin
    fraction_result_t e;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (operand_mon.valid && operand_mon.ready) begin
        expected_fractions.push_back(reduce_fraction(operand_mon.op, operand_mon.left_num,
            operand_mon.left_den, operand_mon.right_num, operand_mon.right_den));
      end
      if (result_mon.valid && result_mon.ready) begin
        if (expected_fractions.size() == 0) begin
          $error("unexpected result");
          fail_count <= fail_count + 1;
        end else begin
          e = expected_fractions.pop_front();
          if (result_mon.result_num !== e.num || result_mon.result_den !== e.den ||
              result_mon.order !== e.ord || result_mon.div_by_zero !== e.dz) begin
            if (result_mon.result_num !== e.num)
              $error("result_num expected %0d actual %0d", e.num, result_mon.result_num);
            if (result_mon.result_den !== e.den)
              $error("result_den expected %0d actual %0d", e.den, result_mon.result_den);
            if (result_mon.order !== e.ord)
              $error("order expected %0d actual %0d", e.ord, result_mon.order);
            if (result_mon.div_by_zero !== e.dz)
              $error("div_by_zero expected %0d actual %0d", e.dz, result_mon.div_by_zero);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending_count <= expected_fractions.size();
  end

endmodule

// File: tb/sv/tb_rational_arithmetic_unit.sv
// Stimulus and verdict for the rational arithmetic unit testbench.
`timescale 1ns / 1ps
module tb_rational_arithmetic_unit;
  import rau_pkg::*;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending_count;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   hold_cycles;
  int   cycle_count;

  rau_in_if  operand();
  rau_out_if result();

  rational_arithmetic_unit uut (.clk(clk), .rst(rst), .operand(operand), .result(result));

  rau_checker checker_inst (
    .clk(clk), .rst(rst), .operand_mon(operand), .result_mon(result),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count = cycle_count + 1;
      if (cycle_count > 400000) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      result.ready <= 1'b0;
    end else begin
      result.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_request(logic [2:0] op, logic [15:0] lnum, logic [14:0] lden,
                              logic [15:0] rnum, logic [14:0] rden);
    while ($urandom_range(99) < send_idle_pct) begin
      operand.valid <= 1'b0;
      @(posedge clk);
    end
    operand.valid <= 1'b1;
    operand.op <= op;
    operand.left_num <= lnum;
    operand.left_den <= lden;
    operand.right_num <= rnum;
    operand.right_den <= rden;
    @(posedge clk);
    while (!operand.ready) @(posedge clk);
  endtask

  task automatic send_random_request();
    logic [2:0]  op;
    logic [15:0] lnum, rnum;
    logic [14:0] lden, rden;
    op = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
    lnum = ($urandom_range(3) == 0) ? 16'($urandom_range(20)) - 16'd10 : 16'($urandom);
    rnum = ($urandom_range(5) == 0) ? 16'd0 : 16'($urandom);
    case ($urandom_range(2))
      0: lden = 15'($urandom_range(32767, 1));
      1: lden = 15'($urandom_range(12, 1));
      default: lden = ($urandom_range(1)) ? 15'h7fff : 15'd1;
    endcase
    rden = ($urandom_range(1)) ? 15'($urandom_range(32767, 1)) : 15'($urandom_range(30, 1));
    if ($urandom_range(7) == 0) begin
      rnum = lnum;
      rden = lden;
    end
    send_request(op, lnum, lden, rnum, rden);
  endtask

  task automatic wait_drained();
    int n;
    n = 0;
    operand.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    while (n < 120) begin
      @(posedge clk);
      n = n + 1;
    end
  endtask

  initial begin
    rst = 1'b1;
    hold_cycles = 0;
    send_idle_pct = 14;
    recv_idle_pct = 81;
    operand.valid = 1'b0;
    operand.op = OP_ADD;
    operand.left_num = '0;
    operand.left_den = 15'd1;
    operand.right_num = '0;
    operand.right_den = 15'd1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_request(OP_ADD, 16'sh7fff, 15'h7fff, 16'sh7fff, 15'h7fff);
    send_request(OP_ADD, 16'sh8000, 15'd1, 16'sh8000, 15'd1);
    send_request(OP_SUB, 16'sh8000, 15'd1, 16'sh7fff, 15'h7fff);
    send_request(OP_SUB, 16'sd3, 15'd4, 16'sd3, 15'd4);
    send_request(OP_MUL, 16'sh8000, 15'd1, 16'sh8000, 15'd1);
    send_request(OP_MUL, 16'sd0, 15'd7, 16'sh7fff, 15'd3);
    send_request(OP_MUL, -16'sd6, 15'd4, 16'sd2, 15'd9);
    send_request(OP_DIV, 16'sd5, 15'd3, 16'sd0, 15'd9);
    send_request(OP_DIV, 16'sd5, 15'd3, -16'sd10, 15'd9);
    send_request(OP_DIV, 16'sh8000, 15'd1, 16'sh8000, 15'h7fff);
    send_request(OP_DIV, -16'sd4, 15'd6, -16'sd2, 15'd3);
    send_request(OP_CMP, 16'sd1, 15'd2, 16'sd2, 15'd4);
    send_request(OP_CMP, -16'sd1, 15'd2, 16'sd1, 15'd3);
    send_request(OP_CMP, 16'sh7fff, 15'd1, 16'sh8000, 15'd1);
    send_request(3'd5, 16'sd1, 15'd1, 16'sd1, 15'd1);
    send_request(3'd6, 16'sh7fff, 15'h7fff, 16'sh8000, 15'd1);
    send_request(3'd7, 16'shffff, 15'h5555, 16'sh5555, 15'h2aaa);
    for (int i = 0; i < 180; i++) send_random_request();
    hold_cycles <= 300;
    for (int i = 0; i < 40; i++) send_random_request();
    wait_drained();
    send_idle_pct = 81;
    recv_idle_pct = 14;
    for (int i = 0; i < 170; i++) send_random_request();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 160; i++) send_random_request();
    wait_drained();
    if (fail_count == 0 && pending_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
